// ----- rtl/core/nonce_replay_cache_assert.svh -----
// Assertion macros shared by the replay cache checker.
// No dependencies; included by the checker file.
`ifndef NONCE_REPLAY_CACHE_ASSERT_SVH
`define NONCE_REPLAY_CACHE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define NRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nonce_replay_cache check failed");

// Next-cycle implication checked outside reset.
`define NRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nonce_replay_cache check failed");

`endif

// ----- rtl/core/nrc_pkg.sv -----
// Package for the nonce replay cache: types, constants and the operation codes.
// No dependencies.
package nrc_pkg;

	localparam int unsigned CapacityDefault = 64;
	localparam int unsigned NonceW = 256;
	localparam int unsigned StampW = 48;
	localparam int unsigned WindowW = 32;
	localparam int unsigned CountW = 7;
	localparam logic [WindowW-1:0] WindowReset = 32'd1000000;

	typedef enum logic [1:0] {
		FUNC_CHECK_ADD = 2'd0,
		FUNC_QUERY     = 2'd1,
		FUNC_PRUNE     = 2'd2,
		FUNC_NONE      = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] nonce_w0;
		logic [63:0] nonce_w1;
		logic [63:0] nonce_w2;
		logic [63:0] nonce_w3;
		logic [47:0] now_ticks;
	} req_t;

	typedef struct packed {
		logic       is_replay;
		logic       stored;
		logic       table_full;
		logic [6:0] entry_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LAST,
		ST_INSERT,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/nonce_replay_cache.sv -----
// Top level of the nonce replay cache: sweep control, valid bits and result register.
// Depends on nrc_pkg and nrc_store.
//
// Channel   Signals                          Handshake
// config    replay_window_we, _wdata         written on any edge with we high
// request   start, busy, req                 accepted when start and not busy
// result    done, rsp                        one-cycle strobe, cannot be held
//
// Every access reads one memory entry per slot through the single read
// port, evaluates each slot after the registered read, then inserts and
// registers the result. Busy falls in the same cycle that done shows. Reset clears
// the valid bits and count at once; the slot memory needs no clearing.
module nonce_replay_cache import nrc_pkg::*; #(
	parameter int unsigned Capacity = CapacityDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 replay_window_we,
	input  logic [WindowW-1:0]   replay_window_wdata,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp
);

	localparam int unsigned AddrW = $clog2(Capacity);
	localparam int unsigned HeldW = $clog2(Capacity + 1);

	state_t state_q, state_d;
	logic [WindowW-1:0] window_q;
	req_t req_q;
	logic [Capacity-1:0] valid_q;
	logic [HeldW-1:0] held_q;
	logic [AddrW-1:0] addr_q, addr_s1;
	logic rd_s1;
	logic hit_q, free_found_q;
	logic [AddrW-1:0] free_q;
	logic expire_en_q;
	logic [StampW-1:0] cutoff_q;
	rsp_t rsp_q;
	logic done_q;

	logic [NonceW-1:0] rd_nonce;
	logic [StampW-1:0] rd_stamp;
	logic [NonceW-1:0] req_nonce;
	logic wr_en;
	logic slot_live, slot_expire, slot_match;

	assign req_nonce = {req_q.nonce_w3, req_q.nonce_w2, req_q.nonce_w1, req_q.nonce_w0};

	nrc_store #(.Capacity(Capacity)) u_store (
		.clk      (clk),
		.rd_addr  (addr_q),
		.rd_nonce (rd_nonce),
		.rd_stamp (rd_stamp),
		.wr_en    (wr_en),
		.wr_addr  (free_q),
		.wr_nonce (req_nonce),
		.wr_stamp (req_q.now_ticks)
	);

	// Slot read in the previous cycle is evaluated now.
	always_comb begin
		slot_live   = rd_s1 && valid_q[addr_s1];
		slot_expire = slot_live && expire_en_q && (rd_stamp < cutoff_q);
		slot_match  = slot_live && !slot_expire && (func_t'(req_q.func) != FUNC_PRUNE)
			&& (rd_nonce == req_nonce);
	end

	always_comb begin
		state_d = state_q;
		wr_en = 1'b0;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_SWEEP;
			ST_SWEEP:  if (addr_q == AddrW'(Capacity - 1)) state_d = ST_LAST;
			ST_LAST:   state_d = ST_INSERT;
			ST_INSERT: begin
				wr_en = (func_t'(req_q.func) == FUNC_CHECK_ADD) && !hit_q && free_found_q;
				state_d = ST_DONE;
			end
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WindowReset;
			valid_q <= '0;
			held_q <= '0;
			addr_q <= '0;
			addr_s1 <= '0;
			rd_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
			if (replay_window_we) begin
				window_q <= replay_window_wdata;
			end
			rd_s1 <= (state_q == ST_SWEEP);
			if (state_q == ST_SWEEP) begin
				addr_q <= addr_q + AddrW'(1);
			end else begin
				addr_q <= '0;
			end
			addr_s1 <= addr_q;
			if (slot_expire) begin
				valid_q[addr_s1] <= 1'b0;
				held_q <= held_q - HeldW'(1);
			end
			if (wr_en) begin
				valid_q[free_q] <= 1'b1;
				held_q <= held_q + HeldW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			free_q <= '0;
			expire_en_q <= ((func_t'(req.func) == FUNC_CHECK_ADD)
				|| (func_t'(req.func) == FUNC_PRUNE))
				&& (req.now_ticks >= StampW'(window_q));
			cutoff_q <= req.now_ticks - StampW'(window_q);
		end
		if (slot_match) begin
			hit_q <= 1'b1;
		end
		// Lowest free slot: invalid before this pass or freed by it.
		if (rd_s1 && !free_found_q && (!valid_q[addr_s1] || slot_expire)) begin
			free_found_q <= 1'b1;
			free_q <= addr_s1;
		end
		if (state_q == ST_INSERT) begin
			rsp_q.is_replay <= hit_q && ((func_t'(req_q.func) == FUNC_CHECK_ADD)
				|| (func_t'(req_q.func) == FUNC_QUERY));
			rsp_q.stored <= wr_en;
			rsp_q.table_full <= (func_t'(req_q.func) == FUNC_CHECK_ADD) && !hit_q
				&& !free_found_q;
		end
		if (state_q == ST_DONE) begin
			rsp_q.entry_count <= (held_q > HeldW'(127)) ? 7'd127 : 7'(held_q);
		end
	end

endmodule

// ----- rtl/core/nrc_store.sv -----
// Slot memory of the replay cache: nonce and stamp per slot, one read and one write port.
// Depends on nrc_pkg.
module nrc_store import nrc_pkg::*; #(
	parameter int unsigned Capacity = CapacityDefault,
	localparam int unsigned AddrW = $clog2(Capacity)
) (
	input  logic              clk,
	input  logic [AddrW-1:0]  rd_addr,
	output logic [NonceW-1:0] rd_nonce,
	output logic [StampW-1:0] rd_stamp,
	input  logic              wr_en,
	input  logic [AddrW-1:0]  wr_addr,
	input  logic [NonceW-1:0] wr_nonce,
	input  logic [StampW-1:0] wr_stamp
);

	logic [NonceW+StampW-1:0] mem [Capacity];
	logic [NonceW+StampW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_nonce, wr_stamp};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_nonce = rd_q[NonceW+StampW-1:StampW];
	assign rd_stamp = rd_q[StampW-1:0];

endmodule

// ----- rtl/core/nrc_checker.sv -----
// Port-level checker for the nonce replay cache, bound to the top level.
// Depends on nrc_pkg and nonce_replay_cache_assert.svh.
`include "nonce_replay_cache_assert.svh"

module nrc_checker import nrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	`NRC_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`NRC_ASSERT_IMP(a_done_busy, clk, arst_n, done, !busy && $past(busy))
	`NRC_ASSERT_IMP(a_one_flag, clk, arst_n, done, !(rsp.stored && (rsp.is_replay || rsp.table_full)))
	`NRC_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

endmodule

bind nonce_replay_cache nrc_checker u_nrc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
